[rtl/core/lpfd_pkg.sv]
// Package for the length-prefixed frame deframer.
// Holds header constants and the result item type; no dependencies.
`timescale 1ns / 1ps

package lpfd_pkg;

    localparam int HeaderBytes = 5;
    localparam int HdrCntW     = 3;
    localparam int LenW        = 32;

    localparam logic [HdrCntW-1:0] HdrLastIdx = HdrCntW'(HeaderBytes - 1);

    typedef struct packed {
        logic [7:0] body_byte;
        logic [7:0] frame_flag;
        logic       frame_last;
        logic       empty_frame;
    } lpfd_result_t;

    // One result item leaving the parser, with its valid mark
    typedef struct packed {
        logic         valid;
        lpfd_result_t data;
    } lpfd_item_t;

endpackage

[rtl/core/lpfd_in_if.sv]
// Input channel: one stream byte per item.
// Standalone interface, no package use.
`timescale 1ns / 1ps

interface lpfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

[rtl/core/lpfd_out_if.sv]
// Output channel: one body byte (or empty-frame mark) per item.
// Standalone interface, no package use.
`timescale 1ns / 1ps

interface lpfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic [7:0] frame_flag;
    logic       frame_last;
    logic       empty_frame;

    modport source (output valid, output body_byte, output frame_flag,
                    output frame_last, output empty_frame, input ready);
    modport sink   (input valid, input body_byte, input frame_flag,
                    input frame_last, input empty_frame, output ready);
endinterface

[rtl/core/length_prefixed_frame_deframer.sv]
// Top level of the length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_in_if, lpfd_out_if, lpfd_parser, lpfd_out_stage.
`timescale 1ns / 1ps
//
// Channel   Dir  Payload                                        Item
// in_ch     in   in_byte[7:0], chunk_end                        one stream byte
// out_ch    out  body_byte[7:0], frame_flag[7:0], frame_last,   one body byte or
//                empty_frame                                    empty-frame mark
//
// Cycles: one byte accepted per cycle while not stalled; its result (if any)
// is visible on out_ch the next cycle from the result register.
// Reset: rst_n clears the header counter, length and body count; the parser
// starts expecting a flag byte and out_ch is empty.
// Stalls: in_ch.ready drops only while a result is held and out_ch.ready is
// low; chunk_end is ignored.

module length_prefixed_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    lpfd_in_if.sink    in_ch,
    lpfd_out_if.source out_ch
);
    import lpfd_pkg::*;

    logic       can_take;
    logic       take;
    lpfd_item_t item;

    // every byte, header or body, waits for a free result slot
    assign in_ch.ready = can_take;
    assign take        = in_ch.valid && can_take;

    lpfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (in_ch.in_byte),
        .item    (item)
    );

    lpfd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .can_take (can_take),
        .out_ch   (out_ch)
    );

endmodule

[rtl/core/lpfd_parser.sv]
// Header/body parser: state registers and per-byte next-state logic.
// Depends on lpfd_pkg.
`timescale 1ns / 1ps

module lpfd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          in_byte,
    output lpfd_pkg::lpfd_item_t item
);
    import lpfd_pkg::*;

    logic [HdrCntW-1:0] hdr_cnt_reg, hdr_cnt_next, hdr_cnt_eff;
    logic [7:0]         flag_reg, flag_next;
    logic [LenW-1:0]    len_reg, len_next;
    logic [LenW-1:0]    remain_reg, remain_next;

    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        flag_next    = flag_reg;
        len_next     = len_reg;
        remain_next  = remain_reg;
        item         = '0;
        item.data.frame_flag = flag_reg;
        // out-of-range count restarts the header
        hdr_cnt_eff  = (hdr_cnt_reg > HdrLastIdx) ? '0 : hdr_cnt_reg;

        if (remain_reg != '0)
        begin
            remain_next          = remain_reg - LenW'(1);
            item.valid           = 1'b1;
            item.data.body_byte  = in_byte;
            item.data.frame_last = (remain_reg == LenW'(1));
        end
        else if (hdr_cnt_eff == '0)
        begin
            flag_next    = in_byte;
            len_next     = '0;
            hdr_cnt_next = HdrCntW'(1);
        end
        else
        begin
            len_next = {len_reg[LenW-9:0], in_byte};
            if (hdr_cnt_eff < HdrLastIdx)
            begin
                hdr_cnt_next = hdr_cnt_eff + HdrCntW'(1);
            end
            else
            begin
                hdr_cnt_next = '0;
                if (len_next == '0)
                begin
                    item.valid            = 1'b1;
                    item.data.frame_last  = 1'b1;
                    item.data.empty_frame = 1'b1;
                end
                else
                begin
                    remain_next = len_next;
                end
            end
        end
        if (!take)
        begin
            item.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= '0;
            flag_reg    <= '0;
            len_reg     <= '0;
            remain_reg  <= '0;
        end
        else if (take)
        begin
            hdr_cnt_reg <= hdr_cnt_next;
            flag_reg    <= flag_next;
            len_reg     <= len_next;
            remain_reg  <= remain_next;
        end
    end

    // body phase only starts from a completed header
    a_body_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (remain_reg != '0) |-> (hdr_cnt_reg == '0))
        else $error("header count nonzero during body");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg <= HdrLastIdx)
        else $error("header count out of range");

    a_last_body: assert property (@(posedge clk) disable iff (!rst_n)
        (take && remain_reg == LenW'(1)) |=> (remain_reg == '0))
        else $error("body count did not end after last byte");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.data.empty_frame) |->
            (item.data.frame_last && item.data.body_byte == 8'd0))
        else $error("empty result malformed");

endmodule

[rtl/core/lpfd_out_stage.sv]
// Result register between parser and output channel.
// Depends on lpfd_pkg and lpfd_out_if.
`timescale 1ns / 1ps

module lpfd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpfd_pkg::lpfd_item_t item,
    output logic                 can_take,
    lpfd_out_if.source           out_ch
);
    import lpfd_pkg::*;

    logic         valid_reg;
    lpfd_result_t data_reg;

    // register is free when empty or being drained this cycle
    assign can_take = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && item.valid)
        begin
            data_reg <= item.data;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.body_byte   = data_reg.body_byte;
    assign out_ch.frame_flag  = data_reg.frame_flag;
    assign out_ch.frame_last  = data_reg.frame_last;
    assign out_ch.empty_frame = data_reg.empty_frame;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ch.ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled result changed");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && !can_take) |-> 1'b0)
        else $error("parser produced result while output full");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (can_take && item.valid) |=> valid_reg)
        else $error("result not loaded");

endmodule
